>>> hdl/skl_pkg.sv
// skl_pkg: shared types and constants of the streaming k-th largest selector
// no dependencies; used by skl_cell, skl_chain and streaming_kth_largest_top

package skl_pkg;

	localparam int VAL_W = 32;
	localparam int RANK_W = 7;

	typedef logic signed [VAL_W-1:0] val_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic shift;   // sorted insertion of the broadcast sample
		logic grow;    // the kept set grows by one entry
		logic clear;   // drop every kept entry
	} skl_ctrl_t;

endpackage

>>> hdl/streaming_kth_largest_top.sv
// streaming_kth_largest_top: top level of the streaming k-th largest selector
// depends on skl_pkg and skl_chain
//
// Usage: samples enter on the input channel (in_valid/in_stall) with
// end_of_set marking the last sample of a set. The block keeps the k largest
// samples of the set in a chain of cells sorted largest first; every cell
// compares the broadcast sample in the same cycle, so one sample is taken per
// clock while in_stall is low. A transfer with end_of_set high sets emit_q,
// which raises in_stall; once the output register is free, the k-th largest
// (or the smallest kept, with underfilled set, if fewer than k were seen) is
// loaded into it, out_valid rises, emit_q drops and the chain is emptied. If
// the receiver holds out_stall, later samples are still taken up to and
// including the next closing one; in_stall then stays high until the output
// register frees. keep_count is written on the cfg channel (cfg_ready is
// always high); the user must write it only while the block is idle, which the
// block itself does not enforce; 0 acts as 1 and values above MAX_KEEP act as
// MAX_KEEP. Reset empties the chain, drops any pending result and sets k to 1.

module streaming_kth_largest_top
	import skl_pkg::*;
#(
	parameter int MAX_KEEP = 64
)(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic        [RANK_W-1:0] keep_count,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [VAL_W-1:0]  sample_value,
	input  logic                     end_of_set,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [VAL_W-1:0]  kth_value,
	output logic                     underfilled
);

	localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

	logic [IDX_W-1:0] rank_idx_q;
	logic [IDX_W-1:0] rank_idx_d;
	logic             emit_q;
	logic             out_valid_q;
	val_t             kth_value_q;
	logic             underfilled_q;
	logic             take;
	logic             load_out;
	val_t             sel_value;
	logic             sel_under;

	assign cfg_ready = 1'b1;
	assign in_stall  = emit_q;
	assign take      = in_valid && !emit_q;
	assign load_out  = emit_q && (!out_valid_q || !out_stall);

	// clamp the rank to 1..MAX_KEEP and keep it as a slot index
	always_comb begin
		if (keep_count == '0) begin
			rank_idx_d = '0;
		end else if (32'(keep_count) > 32'(MAX_KEEP)) begin
			rank_idx_d = IDX_W'(MAX_KEEP - 1);
		end else begin
			rank_idx_d = IDX_W'(32'(keep_count) - 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_idx_q  <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				rank_idx_q <= rank_idx_d;
			end
			if (take && end_of_set) begin
				emit_q <= 1'b1;
			end else if (load_out) begin
				emit_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kth_value_q   <= sel_value;
			underfilled_q <= sel_under;
		end
	end

	skl_chain #(
		.MAX_KEEP (MAX_KEEP),
		.IDX_W    (IDX_W)
	) u_chain (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.sample      (sample_value),
		.clear       (load_out),
		.rank_idx    (rank_idx_q),
		.kth_value   (sel_value),
		.underfilled (sel_under)
	);

	assign out_valid   = out_valid_q;
	assign kth_value   = kth_value_q;
	assign underfilled = underfilled_q;

endmodule

>>> hdl/skl_cell.sv
// skl_cell: one slot of the descending sorted insertion chain
// depends on skl_pkg (val_t, skl_ctrl_t)

module skl_cell
	import skl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  skl_ctrl_t ctrl,
	input  val_t      sample,
	input  val_t      prev_value,
	input  logic      prev_above,
	input  logic      prev_valid,
	output val_t      value,
	output logic      above,
	output logic      valid,
	output logic      beats
);

	val_t value_q;
	logic valid_q;
	logic gt;

	assign gt    = sample > value_q;
	// thermometer: false above the insertion point, true from it downward
	assign above = !valid_q || gt;
	assign beats = valid_q && gt;
	assign value = value_q;
	assign valid = valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift && above) begin
			value_q <= prev_above ? prev_value : sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.grow && prev_valid) begin
			valid_q <= 1'b1;
		end
	end

endmodule

>>> hdl/skl_chain.sv
// skl_chain: row of skl_cell slots holding the kept values, largest first,
// plus insert decision and rank selection; depends on skl_pkg and skl_cell

module skl_chain
	import skl_pkg::*;
#(
	parameter int MAX_KEEP = 64,
	parameter int IDX_W = 6
)(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  val_t             sample,
	input  logic             clear,
	input  logic [IDX_W-1:0] rank_idx,
	output val_t             kth_value,
	output logic             underfilled
);

	val_t            value [MAX_KEEP];
	logic [MAX_KEEP-1:0] above;
	logic [MAX_KEEP-1:0] valid;
	logic [MAX_KEEP-1:0] beats;
	logic [MAX_KEEP-1:0] rank_hit;
	logic [MAX_KEEP-1:0] last_hit;
	logic [MAX_KEEP-1:0] sel;
	logic            full;
	logic            grow;
	skl_ctrl_t       ctrl;

	// fewer than k kept exactly when the rank slot is still empty
	assign full = |(valid & rank_hit);
	assign grow = !full;

	always_comb begin
		ctrl.shift = take && (grow || (|beats));
		ctrl.grow  = take && grow;
		ctrl.clear = clear;
	end

	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		if (i == 0) begin : g_head
			skl_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.sample     (sample),
				.prev_value (sample),
				.prev_above (1'b0),
				.prev_valid (1'b1),
				.value      (value[i]),
				.above      (above[i]),
				.valid      (valid[i]),
				.beats      (beats[i])
			);
		end else begin : g_body
			skl_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (ctrl),
				.sample     (sample),
				.prev_value (value[i-1]),
				.prev_above (above[i-1]),
				.prev_valid (valid[i-1]),
				.value      (value[i]),
				.above      (above[i]),
				.valid      (valid[i]),
				.beats      (beats[i])
			);
		end

		assign rank_hit[i] = (rank_idx == IDX_W'(i));
		if (i == MAX_KEEP - 1) begin : g_tail
			assign last_hit[i] = valid[i];
		end else begin : g_mid
			assign last_hit[i] = valid[i] && !valid[i+1];
		end
		// underfilled set answers with the smallest kept entry
		assign sel[i] = full ? rank_hit[i] : last_hit[i];
	end

	assign underfilled = !full;

	always_comb begin
		kth_value = '0;
		for (int i = 0; i < MAX_KEEP; i++) begin
			kth_value = kth_value | (sel[i] ? value[i] : val_t'(0));
		end
	end

endmodule

>>> tb/sv/tb_streaming_kth_largest_top.sv
// tb_streaming_kth_largest_top: self-checking bench for the streaming k-th largest selector
// depends on skl_pkg and streaming_kth_largest_top; keeps its own sorted store to predict results

`timescale 1ns / 100ps

module tb_streaming_kth_largest_top;
	import skl_pkg::*;

	localparam int MAX_KEEP = 64;
	localparam int N_DIRECTED = 31;
	localparam int RANDOM_ITEMS = 1900;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		val_t kth;
		logic under;
	} rank_result_t;

	typedef struct {
		bit                is_cfg;
		logic [RANK_W-1:0] rank;
		val_t              value;
		bit                eos;
		bit                typed;
		val_t              kth;
		bit                under;
	} step_row_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [RANK_W-1:0]       keep_count;
	logic                    in_valid;
	logic                    in_stall;
	logic signed [VAL_W-1:0] sample_value;
	logic                    end_of_set;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [VAL_W-1:0] kth_value;
	logic                    underfilled;

	// shadow of the selector: ascending store of the kept values
	val_t              top_vals [MAX_KEEP];
	int unsigned       top_cnt;
	logic [RANK_W-1:0] rank_reg;

	rank_result_t pending_results [$];
	int           mismatch_count;
	int           items_sent;
	bit           hold_done;
	val_t         last_drawn;

	step_row_t directed_rows [N_DIRECTED] = '{
		'{1'b0, 7'd0,   32'h7FFFFFFF, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b0},
		'{1'b0, 7'd0,   32'h80000000, 1'b1, 1'b1, 32'h80000000, 1'b0},
		'{1'b0, 7'd0,   5,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   -3,           1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   100,          1'b1, 1'b1, 100,          1'b0},
		// rank 0 behaves as 1
		'{1'b1, 7'd0,   0,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   -7,           1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   9,            1'b1, 1'b0, 0,            1'b0},
		'{1'b1, 7'd3,   0,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   10,           1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   20,           1'b1, 1'b1, 10,           1'b1},
		'{1'b0, 7'd0,   1,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   2,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   3,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   4,            1'b1, 1'b0, 0,            1'b0},
		// equal values never displace the smallest
		'{1'b0, 7'd0,   5,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   5,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   5,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   5,            1'b1, 1'b1, 5,            1'b0},
		// rank above the store size saturates
		'{1'b1, 7'd127, 0,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   -1,           1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   0,            1'b1, 1'b1, -1,           1'b1},
		// rank lowered in the middle of a set
		'{1'b1, 7'd4,   0,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   1,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   2,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   3,            1'b0, 1'b0, 0,            1'b0},
		'{1'b1, 7'd2,   0,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   0,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   10,           1'b1, 1'b0, 0,            1'b0},
		'{1'b1, 7'd64,  0,            1'b0, 1'b0, 0,            1'b0},
		'{1'b0, 7'd0,   32'h80000000, 1'b1, 1'b1, 32'h80000000, 1'b1}
	};

	streaming_kth_largest_top #(
		.MAX_KEEP (MAX_KEEP)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.keep_count   (keep_count),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_value (sample_value),
		.end_of_set   (end_of_set),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kth_value    (kth_value),
		.underfilled  (underfilled)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15_000_000;
		$display("** streaming_kth_largest_top: FAILED **");
		$finish;
	end

	function automatic int unsigned rank_in_use(input logic [RANK_W-1:0] r);
		int unsigned k;
		k = 32'(r);
		if (k < 1) k = 1;
		if (k > MAX_KEEP) k = MAX_KEEP;
		return k;
	endfunction

	function automatic void keep_sorted(input val_t v);
		int unsigned pos;
		pos = top_cnt;
		while (pos > 0 && top_vals[pos-1] > v) begin
			top_vals[pos] = top_vals[pos-1];
			pos--;
		end
		top_vals[pos] = v;
		top_cnt++;
	endfunction

	// returns 1 when the sample closes a set, with the k-th largest (or the smallest kept, with under set) in res
	function automatic bit absorb_sample(input val_t v, input logic eos,
			output rank_result_t res);
		int unsigned k;
		int unsigned idx;
		k = rank_in_use(rank_reg);
		res = '{0, 1'b0};
		if (top_cnt < k) begin
			keep_sorted(v);
		end else if (top_cnt > 0 && v > top_vals[0]) begin
			for (int unsigned i = 1; i < top_cnt; i++)
				top_vals[i-1] = top_vals[i];
			top_cnt--;
			keep_sorted(v);
		end
		if (!eos)
			return 1'b0;
		res.under = (top_cnt < k);
		idx = res.under ? 0 : top_cnt - k;
		res.kth = top_vals[idx];
		top_cnt = 0;
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic val_t draw_value();
		int unsigned r;
		val_t v;
		r = $urandom_range(0, 9);
		case (r)
			0: v = 32'h80000000;
			1: v = 32'h7FFFFFFF;
			2, 3: v = $signed($urandom_range(0, 16)) - 8;
			4: v = last_drawn;
			default: v = $urandom;
		endcase
		last_drawn = v;
		return v;
	endfunction

	task automatic idle_gap(input bit gapless);
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		if (gapless || r < 60) n = 0;
		else if (r < 92) n = $urandom_range(1, 3);
		else n = $urandom_range(8, 30);
		repeat (n) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
	endtask

	task automatic offer_sample(input val_t v, input logic eos, input bit typed,
			input rank_result_t typed_res, input bit gapless);
		rank_result_t res;
		@(negedge clk);
		in_valid = 1'b1;
		sample_value = v;
		end_of_set = eos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (absorb_sample(v, eos, res))
			pending_results.insert(pending_results.size(), typed ? typed_res : res);
		items_sent++;
		idle_gap(gapless);
	endtask

	task automatic set_rank(input logic [RANK_W-1:0] r);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// the chain may still be settling after a sample that closed nothing
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		keep_count = r;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		rank_reg = r;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver: random stall runs, plus one long hold while samples keep coming
	initial begin
		int unsigned r;
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			if (!hold_done && items_sent >= 500) begin
				hold_done = 1'b1;
				@(negedge clk);
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			r = $urandom_range(0, 99);
			if (r < 50) n = $urandom_range(1, 20);
			else if (r < 90) n = $urandom_range(1, 3);
			else n = $urandom_range(10, 40);
			repeat (n) begin
				@(negedge clk);
				out_stall = (r >= 50);
			end
		end
	end

	always @(posedge clk) begin : result_check
		rank_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result kth=%0d under=%0b",
					kth_value, underfilled));
			end else begin
				want = pending_results.pop_front();
				if (kth_value !== want.kth)
					note_mismatch($sformatf("kth_value %0d, expected %0d",
						kth_value, want.kth));
				if (underfilled !== want.under)
					note_mismatch($sformatf("underfilled %0b, expected %0b",
						underfilled, want.under));
			end
		end
	end

	initial begin
		step_row_t row;
		rank_result_t typed_res;
		rank_result_t no_res;
		logic [RANK_W-1:0] r;
		int unsigned k;
		int unsigned sets;
		int unsigned len;
		int unsigned pick;
		bit gapless;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		keep_count = '0;
		in_valid = 1'b0;
		sample_value = '0;
		end_of_set = 1'b0;
		mismatch_count = 0;
		items_sent = 0;
		hold_done = 1'b0;
		last_drawn = 0;
		top_cnt = 0;
		rank_reg = 7'd1;
		no_res = '{0, 1'b0};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_rows[i];
			if (row.is_cfg) begin
				set_rank(row.rank);
			end else begin
				typed_res = '{row.kth, row.under};
				offer_sample(row.value, row.eos, row.typed, typed_res, 1'b0);
			end
		end

		while (items_sent < N_DIRECTED + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: r = 7'd0;
				1: r = 7'd127;
				2: r = 7'd64;
				3: r = 7'($urandom_range(0, 127));
				default: r = 7'($urandom_range(1, 8));
			endcase
			set_rank(r);
			k = rank_in_use(r);
			gapless = ($urandom_range(0, 3) == 0);
			sets = (k > 16) ? $urandom_range(1, 2) : $urandom_range(2, 8);
			for (int s = 0; s < sets; s++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) len = $urandom_range(1, k + 3);
				else if (pick < 90) len = $urandom_range(1, 2 * k + 4);
				else len = $urandom_range(1, 3);
				for (int j = 0; j < len; j++)
					offer_sample(draw_value(), j == len - 1, 1'b0, no_res, gapless);
			end
			// sometimes leave a set open across the next rank change
			if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(1, k);
				for (int j = 0; j < len; j++)
					offer_sample(draw_value(), 1'b0, 1'b0, no_res, gapless);
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("** streaming_kth_largest_top: PASSED **");
		else
			$display("** streaming_kth_largest_top: FAILED **");
		$finish;
	end

endmodule

>>> sim.f
hdl/skl_pkg.sv
hdl/skl_cell.sv
hdl/skl_chain.sv
hdl/streaming_kth_largest_top.sv
tb/sv/tb_streaming_kth_largest_top.sv
